@@ hw/rtl/fab_lz77_decompressor_unit_assert.svh @@
// Assertion macros for the decompressor checker
`ifndef FAB_LZ77_DECOMPRESSOR_UNIT_ASSERT_SVH
`define FAB_LZ77_DECOMPRESSOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FLZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/flz_pkg.sv @@
package flz_pkg;

    localparam int WindowDepth = 8192;
    localparam int HistAw      = $clog2(WindowDepth);
    localparam int CountBits   = 20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_data;
        logic [2:0]  out_count;
        logic [2:0]  status;
        logic        out_last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_DATA = 3'd0,
        ST_DONE = 3'd1,
        ST_HDR  = 3'd2,
        ST_EXH  = 3'd3,
        ST_OVF  = 3'd4,
        ST_OFS  = 3'd5,
        ST_LEN  = 3'd6
    } t_status;

    localparam logic [7:0] MagicF = 8'h46;
    localparam logic [7:0] MagicA = 8'h41;
    localparam logic [7:0] MagicB = 8'h42;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MagicF;
            2'd1:    m = MagicA;
            default: m = MagicB;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/flz_hist_ram.sv @@
module flz_hist_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [flz_pkg::HistAw-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [flz_pkg::HistAw-1:0] i_raddr,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [flz_pkg::WindowDepth];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fab_lz77_decompressor_unit.sv @@
// Channel  Handshake           Payload
// input    i_valid / o_ready   i_in  : in_byte, in_last
// output   o_valid / i_ready   o_out : out_data, out_count, status, out_last
// config   i_cfg_we            i_cfg_data : out_length
// One input word at a time; o_ready is low until its results are queued.
// Each accepted byte passes through an accept step and a finish step; a byte that starts a token
// decode (last header byte, high word byte, literal, no-op extension) first shifts out its control bits.
// A match first checks its offset, then reads and writes each copied byte, then decodes its token bits.
// Synchronous active-low reset; the finish cycle, when it has a word to send, and a fifth copied
// byte wait while the output register holds an unsent word.
module fab_lz77_decompressor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  flz_pkg::t_in_word             i_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output flz_pkg::t_out_word            o_out,
    input  logic                          i_cfg_we,
    input  logic [flz_pkg::CountBits-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_HDR, PH_BITS, PH_WLO, PH_WHI, PH_LIT,
        PH_SOFS, PH_LB0, PH_LB1, PH_EXT, PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        SQ_WAIT, SQ_BITS, SQ_CHK, SQ_RD, SQ_WR, SQ_FIN
    } t_seq;

    t_phase                         r_phase;
    t_seq                           r_seq;
    logic [2:0]                     r_hidx;
    logic [3:0]                     r_shift;
    logic [7:0]                     r_plow;
    logic [16:0]                    r_buf;
    logic [4:0]                     r_bleft;
    logic [1:0]                     r_tok;
    logic                           r_sbit;
    logic [16:0]                    r_dist;
    logic [8:0]                     r_len;
    logic [flz_pkg::CountBits-1:0]  r_pos;
    logic [flz_pkg::CountBits-1:0]  r_olen;
    logic [31:0]                    r_pack;
    logic [2:0]                     r_cnt;
    flz_pkg::t_status               r_stat;
    logic                           r_last;
    logic                           r_ovalid;
    flz_pkg::t_out_word             r_out;

    logic                           accept;
    logic                           slot_free;
    logic [7:0]                     in_b;
    logic [7:0]                     lb_high;
    logic [7:0]                     lb_len;
    logic [16:0]                    lb_dist;
    logic [flz_pkg::CountBits-1:0]  rd_diff;
    logic [7:0]                     rd_data;
    logic                           ram_we;
    logic [7:0]                     ram_wdata;
    flz_pkg::t_status               fin_stat;
    logic                           fin_need;
    logic                           bit_b;

    assign o_ready   = (r_seq == SQ_WAIT);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_ovalid || i_ready;
    assign in_b      = i_in.in_byte;
    assign bit_b     = r_buf[0];
    assign o_valid   = r_ovalid;
    assign o_out     = r_out;
    assign rd_diff   = r_pos - flz_pkg::CountBits'(r_dist);

    always_comb begin
        case (r_shift)
            4'd10: begin
                lb_high = (in_b >> 6) | 8'hFC;
                lb_len  = in_b & 8'h3F;
            end
            4'd11: begin
                lb_high = (in_b >> 5) | 8'hF8;
                lb_len  = in_b & 8'h1F;
            end
            4'd12: begin
                lb_high = (in_b >> 4) | 8'hF0;
                lb_len  = in_b & 8'h0F;
            end
            default: begin
                lb_high = (in_b >> 3) | 8'hE0;
                lb_len  = in_b & 8'h07;
            end
        endcase
        lb_dist = 17'h10000 - {1'b0, lb_high, r_plow};
    end

    always_comb begin
        fin_stat = r_stat;
        if (r_phase != PH_HALT && r_last) begin
            fin_stat = (r_phase == PH_HDR) ? flz_pkg::ST_HDR : flz_pkg::ST_EXH;
        end
        fin_need = (r_cnt != 3'd0) || (fin_stat != flz_pkg::ST_DATA);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = rd_data;
        if (accept && r_phase == PH_LIT) begin
            ram_we    = 1'b1;
            ram_wdata = in_b;
        end else if (r_seq == SQ_WR && (r_cnt != 3'd4 || slot_free)) begin
            ram_we = 1'b1;
        end
    end

    flz_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[flz_pkg::HistAw-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (rd_diff[flz_pkg::HistAw-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_seq    <= SQ_WAIT;
            r_hidx   <= 3'd0;
            r_shift  <= 4'd0;
            r_plow   <= 8'd0;
            r_buf    <= 17'd0;
            r_bleft  <= 5'd16;
            r_tok    <= 2'd0;
            r_sbit   <= 1'b0;
            r_dist   <= 17'd0;
            r_len    <= 9'd0;
            r_pos    <= '0;
            r_olen   <= '0;
            r_pack   <= 32'd0;
            r_cnt    <= 3'd0;
            r_stat   <= flz_pkg::ST_DATA;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_olen <= i_cfg_data;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_seq)
                SQ_WAIT: begin
                    if (accept) begin
                        r_last <= i_in.in_last;
                        r_stat <= flz_pkg::ST_DATA;
                        r_seq  <= SQ_FIN;
                        unique case (r_phase)
                            PH_HDR: begin
                                if (r_hidx < 3'd3) begin
                                    if (in_b != flz_pkg::magic_byte(r_hidx[1:0])) begin
                                        r_stat  <= flz_pkg::ST_HDR;
                                        r_phase <= PH_HALT;
                                    end else begin
                                        r_hidx <= r_hidx + 3'd1;
                                    end
                                end else if (r_hidx == 3'd3) begin
                                    if (in_b < 8'd10 || in_b > 8'd13) begin
                                        r_stat  <= flz_pkg::ST_HDR;
                                        r_phase <= PH_HALT;
                                    end else begin
                                        r_shift <= in_b[3:0];
                                        r_hidx  <= r_hidx + 3'd1;
                                    end
                                end else if (r_hidx == 3'd4) begin
                                    r_plow <= in_b;
                                    r_hidx <= r_hidx + 3'd1;
                                end else begin
                                    r_buf   <= {1'b0, in_b, r_plow};
                                    r_bleft <= 5'd16;
                                    r_tok   <= 2'd0;
                                    r_phase <= PH_BITS;
                                    r_seq   <= SQ_BITS;
                                end
                            end
                            PH_WLO: begin
                                r_plow  <= in_b;
                                r_phase <= PH_WHI;
                            end
                            PH_WHI: begin
                                // old top bit stays in front of the new word
                                r_buf   <= {in_b, r_plow, r_buf[0]};
                                r_bleft <= 5'd17;
                                r_phase <= PH_BITS;
                                r_seq   <= SQ_BITS;
                            end
                            PH_LIT: begin
                                r_pack  <= {24'd0, in_b};
                                r_cnt   <= 3'd1;
                                r_pos   <= r_pos + 1'b1;
                                r_tok   <= 2'd0;
                                r_phase <= PH_BITS;
                                r_seq   <= SQ_BITS;
                            end
                            PH_SOFS: begin
                                r_dist <= 17'd256 - {9'd0, in_b};
                                r_seq  <= SQ_CHK;
                            end
                            PH_LB0: begin
                                r_plow  <= in_b;
                                r_phase <= PH_LB1;
                            end
                            PH_LB1: begin
                                r_dist <= lb_dist;
                                if (lb_len == 8'd0) begin
                                    r_phase <= PH_EXT;
                                end else begin
                                    r_len <= {1'b0, lb_len} + 9'd2;
                                    r_seq <= SQ_CHK;
                                end
                            end
                            PH_EXT: begin
                                if (in_b == 8'd0) begin
                                    r_stat  <= (r_pos == r_olen) ? flz_pkg::ST_DONE
                                                                 : flz_pkg::ST_LEN;
                                    r_phase <= PH_HALT;
                                end else if (in_b == 8'd1) begin
                                    r_tok   <= 2'd0;
                                    r_phase <= PH_BITS;
                                    r_seq   <= SQ_BITS;
                                end else begin
                                    r_len <= {1'b0, in_b} + 9'd1;
                                    r_seq <= SQ_CHK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                SQ_BITS: begin
                    if (r_bleft <= 5'd1) begin
                        r_phase <= PH_WLO;
                        r_seq   <= SQ_FIN;
                    end else begin
                        r_bleft <= r_bleft - 5'd1;
                        r_buf   <= r_buf >> 1;
                        case (r_tok)
                            2'd0: begin
                                if (bit_b) begin
                                    r_seq <= SQ_FIN;
                                    if (r_pos >= r_olen) begin
                                        r_stat  <= flz_pkg::ST_OVF;
                                        r_phase <= PH_HALT;
                                    end else begin
                                        r_phase <= PH_LIT;
                                    end
                                end else begin
                                    r_tok <= 2'd1;
                                end
                            end
                            2'd1: begin
                                if (bit_b) begin
                                    r_phase <= PH_LB0;
                                    r_seq   <= SQ_FIN;
                                end else begin
                                    r_tok <= 2'd2;
                                end
                            end
                            2'd2: begin
                                r_sbit <= bit_b;
                                r_tok  <= 2'd3;
                            end
                            default: begin
                                r_len   <= {7'd0, r_sbit, bit_b} + 9'd2;
                                r_phase <= PH_SOFS;
                                r_seq   <= SQ_FIN;
                            end
                        endcase
                    end
                end
                SQ_CHK: begin
                    if (flz_pkg::CountBits'(r_dist) > r_pos) begin
                        r_stat  <= flz_pkg::ST_OFS;
                        r_phase <= PH_HALT;
                        r_seq   <= SQ_FIN;
                    end else begin
                        r_seq <= SQ_RD;
                    end
                end
                SQ_RD: begin
                    if (r_pos >= r_olen) begin
                        r_stat  <= flz_pkg::ST_OVF;
                        r_phase <= PH_HALT;
                        r_seq   <= SQ_FIN;
                    end else begin
                        r_seq <= SQ_WR;
                    end
                end
                SQ_WR: begin
                    if (r_cnt != 3'd4 || slot_free) begin
                        if (r_cnt == 3'd4) begin
                            r_ovalid        <= 1'b1;
                            r_out.out_data  <= r_pack;
                            r_out.out_count <= 3'd4;
                            r_out.status    <= flz_pkg::ST_DATA;
                            r_out.out_last  <= 1'b0;
                            r_pack          <= {24'd0, rd_data};
                            r_cnt           <= 3'd1;
                        end else begin
                            r_pack[8*r_cnt[1:0] +: 8] <= rd_data;
                            r_cnt                     <= r_cnt + 3'd1;
                        end
                        r_pos <= r_pos + 1'b1;
                        r_len <= r_len - 9'd1;
                        if (r_len == 9'd1) begin
                            r_tok   <= 2'd0;
                            r_phase <= PH_BITS;
                            r_seq   <= SQ_BITS;
                        end else begin
                            r_seq <= SQ_RD;
                        end
                    end
                end
                SQ_FIN: begin
                    if (!fin_need || slot_free) begin
                        if (fin_need) begin
                            r_ovalid        <= 1'b1;
                            r_out.out_data  <= r_pack;
                            r_out.out_count <= r_cnt;
                            r_out.status    <= fin_stat;
                            r_out.out_last  <= 1'b1;
                        end
                        if (r_last) begin
                            r_phase <= PH_HALT;
                        end
                        r_pack <= 32'd0;
                        r_cnt  <= 3'd0;
                        r_seq  <= SQ_WAIT;
                    end
                end
                default: begin
                    r_seq <= SQ_WAIT;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/flz_checker.sv @@
`include "fab_lz77_decompressor_unit_assert.svh"

module flz_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input flz_pkg::t_out_word o_out
);

    `FLZ_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_out), "output word dropped or changed under stall")
    `FLZ_ASSERT_NOW(a_count_range, o_valid, o_out.out_count <= 3'd4, "out_count above four")
    `FLZ_ASSERT_NOW(a_status_last, o_valid && o_out.status != flz_pkg::ST_DATA, o_out.out_last, "status on a word that is not last")
    `FLZ_ASSERT_NOW(a_empty_status, o_valid && o_out.out_count == 3'd0, o_out.status != flz_pkg::ST_DATA && o_out.out_last, "empty word without status")
    `FLZ_ASSERT_NOW(a_mid_full, o_valid && !o_out.out_last, o_out.out_count == 3'd4, "word before the last not full")

endmodule

bind fab_lz77_decompressor_unit flz_checker u_flz_checker (.*);

@@ test/fab_lz77_decompressor_unit_tb.sv @@
`timescale 1ns / 100ps

module fab_lz77_decompressor_unit_tb;

    typedef enum int {
        P_HDR, P_BITS, P_WLO, P_WHI, P_LIT, P_SOFS, P_LB0, P_LB1, P_EXT, P_HALT
    } t_phase;

    typedef struct {
        logic [7:0] b;
        bit         lit;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    flz_pkg::t_in_word             i_in;
    logic                          o_valid;
    logic                          i_ready;
    flz_pkg::t_out_word            o_out;
    logic                          i_cfg_we;
    logic [flz_pkg::CountBits-1:0] i_cfg_data;

    fab_lz77_decompressor_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // decoder shadow state
    logic [7:0]  hist [flz_pkg::WindowDepth];
    int unsigned bbuf, bleft, hidx, shv, plo, opos, olen, tstep, sbits, mdist, mlen;
    t_phase      ph;
    flz_pkg::t_status dec_status;
    logic [7:0]  dec_bytes [$];

    flz_pkg::t_out_word words_due [$];
    int          errors;
    int          words_seen;
    int          bytes_sent;
    bit          calm;
    int          rdy_hold;
    int unsigned gen_dist;
    int          end_mode;
    bit          endgame;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void dec_halt(flz_pkg::t_status s);
        dec_status = s;
        ph = P_HALT;
    endfunction

    function automatic void dec_put(logic [7:0] v);
        hist[opos % flz_pkg::WindowDepth] = v;
        dec_bytes.push_back(v);
        opos = (opos + 1) & ((1 << flz_pkg::CountBits) - 1);
    endfunction

    function automatic void dec_bit(int unsigned b);
        case (tstep)
            0: begin
                if (b) begin
                    if (opos >= olen) dec_halt(flz_pkg::ST_OVF);
                    else ph = P_LIT;
                end else begin
                    tstep = 1;
                end
            end
            1: begin
                if (b) ph = P_LB0;
                else tstep = 2;
            end
            2: begin
                sbits = b;
                tstep = 3;
            end
            default: begin
                mlen = ((sbits << 1) | b) + 2;
                ph = P_SOFS;
            end
        endcase
    endfunction

    function automatic void dec_run_bits();
        int unsigned b;
        while (ph == P_BITS) begin
            if (bleft <= 1) begin
                ph = P_WLO;
                return;
            end
            bleft--;
            b = bbuf & 1;
            bbuf >>= 1;
            dec_bit(b);
        end
    endfunction

    function automatic void dec_token();
        tstep = 0;
        ph = P_BITS;
        dec_run_bits();
    endfunction

    function automatic void dec_copy();
        if (mdist > opos) begin
            dec_halt(flz_pkg::ST_OFS);
            return;
        end
        for (int unsigned n = 0; n < mlen; n++) begin
            if (opos >= olen) begin
                dec_halt(flz_pkg::ST_OVF);
                return;
            end
            dec_put(hist[(opos - mdist) % flz_pkg::WindowDepth]);
        end
        dec_token();
    endfunction

    function automatic void dec_byte(int unsigned v);
        int unsigned sh, osh, omask, lmask, hi, b;
        case (ph)
            P_HDR: begin
                if (hidx < 3) begin
                    if (v != flz_pkg::magic_byte(hidx[1:0])) begin
                        dec_halt(flz_pkg::ST_HDR);
                        return;
                    end
                end else if (hidx == 3) begin
                    if (v < 10 || v > 13) begin
                        dec_halt(flz_pkg::ST_HDR);
                        return;
                    end
                    shv = v;
                end else if (hidx == 4) begin
                    plo = v;
                end else begin
                    bbuf = plo | (v << 8);
                    bleft = 16;
                    dec_token();
                    return;
                end
                hidx++;
            end
            P_WLO: begin
                plo = v;
                ph = P_WHI;
            end
            P_WHI: begin
                bbuf = (((plo | (v << 8)) << 1) | (bbuf & 1)) & 32'h1FFFF;
                bleft = 16;
                b = bbuf & 1;
                bbuf >>= 1;
                ph = P_BITS;
                dec_bit(b);
                dec_run_bits();
            end
            P_LIT: begin
                dec_put(v[7:0]);
                dec_token();
            end
            P_SOFS: begin
                mdist = 256 - v;
                dec_copy();
            end
            P_LB0: begin
                plo = v;
                ph = P_LB1;
            end
            P_LB1: begin
                sh = shv & 15;
                if (sh < 10 || sh > 13) sh = 13;
                osh = 16 - sh;
                omask = (32'hFF << (sh - 8)) & 32'hFF;
                lmask = (1 << osh) - 1;
                hi = ((v >> osh) | omask) & 32'hFF;
                mdist = 32'h10000 - ((hi << 8) | plo);
                mlen = v & lmask;
                if (mlen == 0) begin
                    ph = P_EXT;
                end else begin
                    mlen += 2;
                    dec_copy();
                end
            end
            P_EXT: begin
                if (v == 0) dec_halt(opos == olen ? flz_pkg::ST_DONE : flz_pkg::ST_LEN);
                else if (v == 1) dec_token();
                else begin
                    mlen = v + 1;
                    dec_copy();
                end
            end
            default: ;
        endcase
    endfunction

    // runs one stream byte through the shadow decoder; pushes its words unless typed
    function automatic void decode_step(logic [7:0] v, logic last, bit typed);
        int nres;
        int cnt;
        flz_pkg::t_out_word w;
        if (ph == P_HALT) return;
        dec_bytes.delete();
        dec_status = flz_pkg::ST_DATA;
        dec_byte(v);
        if (ph != P_HALT && last) dec_halt(ph == P_HDR ? flz_pkg::ST_HDR : flz_pkg::ST_EXH);
        if (typed) return;
        nres = (dec_bytes.size() + 3) / 4;
        if (nres == 0 && dec_status != flz_pkg::ST_DATA) nres = 1;
        for (int k = 0; k < nres; k++) begin
            cnt = dec_bytes.size() - 4 * k;
            if (cnt < 0) cnt = 0;
            if (cnt > 4) cnt = 4;
            w = '0;
            for (int i = 0; i < cnt; i++) w.out_data[8*i +: 8] = dec_bytes[4*k + i];
            w.out_count = 3'(cnt);
            w.status = (k + 1 == nres) ? dec_status : flz_pkg::ST_DATA;
            w.out_last = (k + 1 == nres);
            words_due.push_back(w);
        end
    endfunction

    function automatic logic [7:0] stream_byte();
        int unsigned m, maxd, t, lenf, osh, r;
        m = (32'hFF << (shv - 8)) & 32'hFF;
        osh = 16 - shv;
        case (ph)
            P_SOFS: begin
                if (endgame && end_mode == 3 && opos < 256) return 8'(255 - opos);
                return 8'(256 - $urandom_range(1, opos < 256 ? opos : 256));
            end
            P_LB0: begin
                maxd = (256 - m) << 8;
                if (endgame && end_mode == 3 && opos < maxd) gen_dist = opos + 1;
                else gen_dist = $urandom_range(1, opos < maxd ? opos : maxd);
                return 8'((32'h10000 - gen_dist) & 32'hFF);
            end
            P_LB1: begin
                t = ((32'h10000 - gen_dist) >> 8) & 32'hFF;
                r = $urandom_range(0, 7);
                if ((endgame && end_mode == 2) || r == 0) lenf = 0;
                else lenf = $urandom_range(1, r < 6 ? 6 : (1 << osh) - 1);
                return 8'((((t & ~m) << osh) | lenf) & 32'hFF);
            end
            P_EXT: begin
                r = $urandom_range(0, 19);
                if (endgame && end_mode == 2) return 8'd0;
                if (r < 10) return 8'd1;
                if (r < 19) return 8'($urandom_range(2, 20));
                return 8'd255;
            end
            P_WLO, P_WHI: begin
                if (endgame && end_mode == 2) return 8'hAA;
                return 8'($urandom_range(0, 255));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(logic [7:0] v, logic last, bit typed);
        int g;
        i_in <= '{in_byte: v, in_last: last};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        decode_step(v, last, typed);
        if (typed) words_due.push_back('{out_data: {24'h0, v}, out_count: 3'd1,
                                        status: flz_pkg::ST_DATA, out_last: 1'b1});
        bytes_sent++;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_out_length(int unsigned v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[flz_pkg::CountBits-1:0];
        @(posedge i_clk);
        olen = v & ((1 << flz_pkg::CountBits) - 1);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
            i_ready <= 1'b0;
        end else begin
            rdy_hold = pick_gap();
            i_ready <= (rdy_hold == 0);
            if (rdy_hold > 0) rdy_hold--;
        end
    end

    always @(posedge i_clk) begin
        flz_pkg::t_out_word w;
        if (i_rst_n && o_valid && i_ready) begin
            words_seen++;
            if (words_due.size() == 0) begin
                report("unexpected word", o_out, 0);
            end else begin
                w = words_due.pop_front();
                if (o_out.out_data !== w.out_data) report("data", o_out.out_data, w.out_data);
                if (o_out.out_count !== w.out_count)
                    report("count", o_out.out_count, w.out_count);
                if (o_out.status !== w.status) report("status", o_out.status, w.status);
                if (o_out.out_last !== w.out_last)
                    report("last", o_out.out_last, w.out_last);
            end
        end
    end

    initial begin
        #50ms;
        $display("fab_lz77_decompressor_unit regression: fail");
        $finish;
    end

    t_row rows [24] = '{
        '{8'h46, 0}, '{8'h41, 0}, '{8'h42, 0}, '{8'h0A, 0}, '{8'hCF, 0}, '{8'h86, 0},
        '{8'h00, 1}, '{8'hFF, 1}, '{8'h55, 1}, '{8'hAA, 1},
        '{8'hFC, 0},
        '{8'hF7, 0}, '{8'hC3, 0},
        '{8'h80, 1},
        '{8'hFF, 0},
        '{8'h0A, 0}, '{8'hFF, 0},
        '{8'h7E, 1},
        '{8'hF0, 0}, '{8'hC0, 0}, '{8'h01, 0},
        '{8'hFE, 0}, '{8'hC0, 0}, '{8'h02, 0}
    };

    initial begin
        int k;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        words_seen = 0;
        bytes_sent = 0;
        calm = 1'b0;
        rdy_hold = 0;
        endgame = 1'b0;
        bbuf = 0; bleft = 16; ph = P_HDR; hidx = 0; shv = 0; plo = 0;
        opos = 0; olen = 0; tstep = 0; sbits = 0; mdist = 0; mlen = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_out_length(0);
        write_out_length((1 << flz_pkg::CountBits) - 1);

        foreach (rows[i]) send_byte(rows[i].b, 1'b0, rows[i].lit);

        // well-formed tokens with random content
        for (k = 0; k < 96 && ph != P_HALT; k++) begin
            if (k % 30 == 0) calm = $urandom_range(0, 2) == 0;
            if (k % 40 == 39) write_out_length($urandom_range(opos + 50000, 1048575));
            send_byte(stream_byte(), 1'b0, 1'b0);
        end

        // close the stream: cut short, overflow, end marker or bad offset
        calm = 1'b0;
        end_mode = $urandom_range(0, 3);
        endgame = 1'b1;
        if (end_mode == 1) write_out_length(opos);
        for (k = 0; k < 80 && ph != P_HALT; k++) begin
            if (end_mode == 2 && ph == P_EXT && $urandom_range(0, 1)) write_out_length(opos);
            send_byte(stream_byte(), end_mode == 0 || k == 79, 1'b0);
        end

        i_valid <= 1'b0;
        k = 0;
        while (words_due.size() != 0 && k < 100000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (100) @(posedge i_clk);

        $display("sent %0d stream bytes, checked %0d output words, %0d bytes decoded",
                 bytes_sent, words_seen, opos);
        $display("stream closed by ending kind %0d with status %0d, %0d words outstanding",
                 end_mode, dec_status, words_due.size());
        if (errors == 0 && words_due.size() == 0) begin
            $display("fab_lz77_decompressor_unit regression: pass");
        end else begin
            $display("fab_lz77_decompressor_unit regression: fail");
        end
        $finish;
    end

endmodule
